// File: design/insertion_sorter_core_macros.svh
// Assertion helpers used by the sorter core.
`ifndef INSERTION_SORTER_CORE_MACROS_SVH
`define INSERTION_SORTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ISC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ISC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and sizes for the insertion sorter chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isort_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
    logic                      overflow;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast value
    logic drain;  // shift every entry one place toward cell 0
  } cell_ctrl_t;

endpackage

// File: design/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain: compare against the broadcast value and
// shift up on insertion or down on drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isort_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isort_pkg::cell_ctrl_t               ctrl,
  input  logic signed [isort_pkg::VALUE_W-1:0] new_value,
  input  logic signed [isort_pkg::VALUE_W-1:0] prev_val,
  input  logic                                prev_valid,
  input  logic                                prev_lt,
  input  logic signed [isort_pkg::VALUE_W-1:0] next_val,
  input  logic                                next_valid,
  output logic signed [isort_pkg::VALUE_W-1:0] val,
  output logic                                valid,
  output logic                                lt
);
  import isort_pkg::*;

  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      valid_r, valid_nxt;

  // An empty slot counts as greater than anything, so it always accepts.
  // Strict compare keeps equal values in arrival order.
  assign lt = !valid_r || (new_value < val_r);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.drain) begin
      val_nxt   = next_val;
      valid_nxt = next_valid;
    end else if (ctrl.ins && lt) begin
      if (prev_lt) begin
        val_nxt   = prev_val;
        valid_nxt = prev_valid;
      end else begin
        val_nxt   = new_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

// File: design/insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Stable insertion sorter built from a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one signed value and a last flag per transfer. While a set
//   is loading, in_ready is high and one value is inserted per cycle: every
//   cell compares against the broadcast value and the larger entries shift up.
//   A set keeps its first DEPTH values; later ones are dropped and every
//   result of that set then carries overflow.
//   The transfer marked last starts the drain. in_ready drops and the chain
//   shifts toward cell 0 into the output register, one entry per cycle unless
//   out_ready stalls. After the last transfer the draining flag is registered
//   first, then the first result is loaded into the output register; a stall
//   on out_ready simply holds the chain. final_res marks the set's last result.
//   in_ready rises again in the cycle after the final result is loaded, even
//   while that result still waits in the output register.
//   Reset (rst_n low, synchronous) empties the chain and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "insertion_sorter_core_macros.svh"

module insertion_sorter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  isort_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output isort_pkg::out_item_t out_data
);
  import isort_pkg::*;

  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          cell_lt;
  cell_ctrl_t                ctrl;

  logic      draining_r, draining_nxt;
  logic      dropped_r, dropped_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      in_xfer, full, load;

  assign in_ready = !draining_r;
  assign in_xfer  = in_valid && in_ready;
  assign full     = cell_valid[DEPTH-1];
  assign load     = draining_r && cell_valid[0] && (!out_valid_r || out_ready);

  assign ctrl.ins   = in_xfer && !full;
  assign ctrl.drain = load;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] p_val, n_val;
    logic                      p_valid, p_lt, n_valid;
    if (i == 0) begin : g_first
      assign p_val   = '0;
      assign p_valid = 1'b0;
      assign p_lt    = 1'b0;
    end else begin : g_mid
      assign p_val   = cell_val[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_lt    = cell_lt[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign n_val   = '0;
      assign n_valid = 1'b0;
    end else begin : g_up
      assign n_val   = cell_val[i+1];
      assign n_valid = cell_valid[i+1];
    end
    isort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_value  (in_data.value),
      .prev_val   (p_val),
      .prev_valid (p_valid),
      .prev_lt    (p_lt),
      .next_val   (n_val),
      .next_valid (n_valid),
      .val        (cell_val[i]),
      .valid      (cell_valid[i]),
      .lt         (cell_lt[i])
    );
  end

  always_comb begin
    draining_nxt  = draining_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_data.last) begin
        draining_nxt = 1'b1;
      end
    end
    if (load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.sorted_value = cell_val[0];
      out_data_nxt.final_res    = !cell_valid[1];
      out_data_nxt.overflow     = dropped_r;
      // The set ends as its final entry leaves the chain.
      if (!cell_valid[1]) begin
        draining_nxt = 1'b0;
        dropped_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r  <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      draining_r  <= draining_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Occupied cells always form a contiguous run starting at cell 0.
  `ISC_ASSERT_NOW(a_thermometer, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0, "chain has a hole")
  // Loading the final entry leaves the chain empty and ready for a new set.
  `ISC_ASSERT_NEXT(a_drain_end, load && !cell_valid[1], !cell_valid[0] && in_ready, "drain stuck")
  // A value offered to a full chain marks the set as overflowed.
  `ISC_ASSERT_NEXT(a_drop_flag, in_xfer && full && !in_data.last, dropped_r, "drop not recorded")

endmodule
